>>> rtl/rcbp_pkg.sv
// Shared types, widths and constants of the Rice code bit packer.
package rcbp_pkg;

  localparam int WORD_W            = 32;
  localparam int MAX_ZERO_RUN_BITS = 1984;

  localparam int V_W    = 33;   // folded value, one bit wider than the input word
  localparam int K_W    = 7;    // coding parameter, up to 64 for the signed form
  localparam int NBIT_W = 6;    // bit length of a long value, 0..32
  localparam int T_W    = 36;   // longest tail: long code, 3 + 33 bits
  localparam int L_W    = 6;    // tail length, up to 36
  localparam int FILL_W = 5;
  localparam int RUN_W  = $clog2(MAX_ZERO_RUN_BITS + 1);
  localparam int SUM_W  = RUN_W + 1;
  localparam int TSUM_W = L_W + 1;

  typedef enum logic [1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_LONG     = 2'd2,
    OP_FLUSH    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_PARAM = 2'd1,
    ERR_RUN   = 2'd2
  } err_code_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_RUN   = 5'b00100,
    S_TAIL  = 5'b01000,
    S_ERR   = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic run_step;
    logic tail_step;
    logic err_emit;
  } rcbp_cmd_t;

  typedef struct packed {
    logic setup_err;
    logic run_emit;
    logic run_rem_zero;
    logic tail_emit;
    logic tail_done;
    logic out_free;
  } rcbp_stat_t;

endpackage

>>> rtl/rcbp_ctrl.sv
// Sequencer of the Rice code bit packer: accept, set up, then zero run and tail, or an error result.
module rcbp_ctrl
  import rcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  rcbp_stat_t stat,
  output rcbp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.setup_err ? S_ERR : S_RUN;
      end
      S_RUN: begin
        // hold while a finished word cannot be handed on
        cmd.run_step = !stat.run_emit || stat.out_free;
        if (cmd.run_step && (!stat.run_emit || stat.run_rem_zero)) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail_step = !stat.tail_emit || stat.out_free;
        if (cmd.tail_step && stat.tail_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.err_emit = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/rcbp_datapath.sv
// Datapath of the Rice code bit packer: code setup, packing word and output register.
module rcbp_datapath
  import rcbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_opcode,
  input  logic [WORD_W-1:0]    in_value,
  input  logic [5:0]           in_rice_k,
  input  rcbp_cmd_t            cmd,
  output rcbp_stat_t           stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_packed_word,
  output logic                 out_last_of_run,
  output logic [1:0]           out_error_code
);

  // captured request
  opcode_t           op_r;
  logic [V_W-1:0]    v_r;
  logic [K_W-1:0]    k_r;
  logic [NBIT_W-1:0] nbit_r;

  // code in flight: zero run, then tail bits
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [T_W-1:0]    tail_r, tail_nxt;
  logic [L_W-1:0]    len_r, len_nxt;
  err_code_t         errc_r, errc_nxt;

  // packing state
  logic [WORD_W-1:0] partial_r, partial_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // output register
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;
  err_code_t         out_err_r;

  logic              emit;
  logic [WORD_W-1:0] emit_word;
  logic              emit_last;
  err_code_t         emit_err;

  logic [NBIT_W-1:0] nbit_in;
  logic [V_W-1:0]    v_in;
  logic [K_W-1:0]    k_in;

  logic [V_W-1:0]    run_full;
  logic [5:0]        k6;
  logic [T_W-1:0]    k_bit, k_mask, t_rice, t_long;
  err_code_t         setup_err_code;

  logic [SUM_W-1:0]  rsum, rrem;
  logic [TSUM_W-1:0] tsum;
  logic [L_W-1:0]    tsh, tshl;
  logic [T_W-1:0]    tail_shr, tail_shl;

  // bit length of the input word
  always_comb begin
    nbit_in = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (in_value[i]) nbit_in = NBIT_W'(i + 1);
    end
  end

  always_comb begin
    v_in = {1'b0, in_value};
    k_in = '0;
    case (opcode_t'(in_opcode))
      OP_UNSIGNED: k_in = {1'b0, in_rice_k};
      OP_SIGNED: begin
        // fold sign into the low bit
        v_in = in_value[WORD_W-1] ? {~in_value, 1'b1} : {in_value, 1'b0};
        k_in = {1'b0, in_rice_k} + K_W'(1);
      end
      default: k_in = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= opcode_t'(in_opcode);
      v_r    <= v_in;
      k_r    <= k_in;
      nbit_r <= nbit_in;
    end
  end

  // code setup
  assign run_full = v_r >> k_r;
  assign k6       = k_r[5:0];
  assign k_bit    = T_W'(1) << k6;
  assign k_mask   = k_bit - T_W'(1);
  assign t_rice   = k_bit | (T_W'(v_r) & k_mask);
  // long code: bit length with k of two, then the value behind its leading one
  assign t_long   = (T_W'({1'b1, nbit_r[1:0]}) << (nbit_r + NBIT_W'(1)))
                  | (T_W'(1) << nbit_r) | T_W'(v_r);

  always_comb begin
    setup_err_code = ERR_OK;
    if (op_r == OP_UNSIGNED || op_r == OP_SIGNED) begin
      if (k_r > K_W'(WORD_W)) begin
        setup_err_code = ERR_PARAM;
      end else if (run_full > V_W'(MAX_ZERO_RUN_BITS)) begin
        setup_err_code = ERR_RUN;
      end
    end
  end

  // packing arithmetic
  assign rsum     = SUM_W'(fill_r) + SUM_W'(run_r);
  assign rrem     = rsum - SUM_W'(WORD_W) + SUM_W'(len_r);
  assign tsum     = TSUM_W'(fill_r) + TSUM_W'(len_r);
  assign tsh      = L_W'(tsum - TSUM_W'(WORD_W));
  assign tshl     = L_W'(TSUM_W'(WORD_W) - tsum);
  assign tail_shr = tail_r >> tsh;
  assign tail_shl = tail_r << tshl;

  always_comb begin
    stat.setup_err    = (setup_err_code != ERR_OK);
    stat.run_emit     = (rsum >= SUM_W'(WORD_W));
    stat.run_rem_zero = (rsum == SUM_W'(WORD_W));
    stat.tail_emit    = (tsum >= TSUM_W'(WORD_W));
    stat.tail_done    = !stat.tail_emit || (tsh == '0) || (op_r == OP_FLUSH);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  always_comb begin
    run_nxt     = run_r;
    tail_nxt    = tail_r;
    len_nxt     = len_r;
    errc_nxt    = errc_r;
    partial_nxt = partial_r;
    fill_nxt    = fill_r;
    emit        = 1'b0;
    emit_word   = partial_r;
    emit_last   = 1'b0;
    emit_err    = ERR_OK;

    if (cmd.setup) begin
      errc_nxt = setup_err_code;
      case (op_r)
        OP_UNSIGNED, OP_SIGNED: begin
          run_nxt  = run_full[RUN_W-1:0];
          tail_nxt = t_rice;
          len_nxt  = L_W'(k6) + L_W'(1);
        end
        OP_LONG: begin
          run_nxt  = RUN_W'(nbit_r >> 2);
          tail_nxt = t_long;
          len_nxt  = L_W'(nbit_r) + L_W'(4);
        end
        default: begin
          // flush marker: zero coded with k of 31
          run_nxt  = '0;
          tail_nxt = T_W'(1) << (WORD_W - 1);
          len_nxt  = L_W'(WORD_W);
        end
      endcase
    end

    if (cmd.run_step) begin
      if (stat.run_emit) begin
        emit        = 1'b1;
        emit_word   = partial_r;
        emit_last   = (rrem < SUM_W'(WORD_W));
        run_nxt     = RUN_W'(rsum - SUM_W'(WORD_W));
        partial_nxt = '0;
        fill_nxt    = '0;
      end else begin
        fill_nxt = rsum[FILL_W-1:0];
        run_nxt  = '0;
      end
    end

    if (cmd.tail_step) begin
      if (stat.tail_emit) begin
        emit        = 1'b1;
        emit_word   = partial_r | tail_shr[WORD_W-1:0];
        emit_last   = (tsh < L_W'(WORD_W));
        len_nxt     = tsh;
        partial_nxt = '0;
        fill_nxt    = '0;
      end else begin
        fill_nxt    = tsum[FILL_W-1:0];
        partial_nxt = partial_r | tail_shl[WORD_W-1:0];
        len_nxt     = '0;
      end
      // flush drops what is left of the word
      if (stat.tail_done && op_r == OP_FLUSH) begin
        partial_nxt = '0;
        fill_nxt    = '0;
      end
    end

    if (cmd.err_emit) begin
      emit      = 1'b1;
      emit_word = '0;
      emit_last = 1'b1;
      emit_err  = errc_r;
    end
  end

  always_ff @(posedge clk) begin
    run_r  <= run_nxt;
    tail_r <= tail_nxt;
    len_r  <= len_nxt;
    errc_r <= errc_nxt;
    if (emit) begin
      out_word_r <= emit_word;
      out_last_r <= emit_last;
      out_err_r  <= emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;
  assign out_last_of_run = out_last_r;
  assign out_error_code  = out_err_r;

  // a word is only produced into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> stat.out_free)
    else $error("word produced while output register is occupied");

  // flush leaves an empty packing word
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tail_step && stat.tail_done && op_r == OP_FLUSH) |=>
      (fill_r == '0 && partial_r == '0))
    else $error("packing word not cleared after flush");

  // error results carry an empty word and close the request
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_OK) |-> (out_word_r == '0 && out_last_r))
    else $error("malformed error result");

  // an empty packing word holds no stale bits
  a_partial_low: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (partial_r == '0))
    else $error("stale bits in empty packing word");

endmodule

>>> rtl/rice_code_bit_packer.sv
// Top level of the Rice code bit packer: sequencer and datapath.
// Packs one Rice code per request MSB-first into 32-bit words (unsigned, sign
// folded, long form with its bit length coded first, or a flush marker that
// ends the word). A request is accepted, its code set up, then it passes a
// zero-run stage and a tail stage. The zero-run stage emits a word for each
// 32 bits completed by the word fill plus the zero run. The tail stage emits a
// word for each 32 bits completed by the fill plus the tail bits, and a flush
// emits a single word there. The packing register completes at most one word
// per cycle. When neither sum exceeds 32 bits a request passes the accept,
// setup, zero-run and tail states once each before the next acceptance. A
// stalled output holds any stage that has a word to hand on. Error requests
// go from setup to an error state and give one result with an empty word.
// Results arrive through one output register, each request's final word marked by out_last_of_run.
module rice_code_bit_packer
  import rcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [WORD_W-1:0] in_value,
  input  logic [5:0]        in_rice_k,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_packed_word,
  output logic              out_last_of_run,
  output logic [1:0]        out_error_code
);

  rcbp_cmd_t  cmd;
  rcbp_stat_t stat;

  rcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcbp_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_rice_k       (in_rice_k),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_word (out_packed_word),
    .out_last_of_run (out_last_of_run),
    .out_error_code  (out_error_code)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the Rice code bit packer.
`timescale 1ns / 1ps

module tb_top;
  import rcbp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    opcode_t     op;
    logic [31:0] value;
    logic [5:0]  rice_k;
  } req_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    err_code_t   err;
  } word_res_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = 2'd0;
  logic [WORD_W-1:0] in_value = '0;
  logic [5:0]        in_rice_k = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_packed_word;
  logic              out_last_of_run;
  logic [1:0]        out_error_code;

  req_t      pending_reqs[$];
  word_res_t expected_words[$];

  // predictor state: unfinished word, top-aligned, and its bit count
  logic [31:0] pend_word = '0;
  logic [4:0]  pend_fill = '0;

  logic in_fire = 1'b0;
  int   sent_count = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic calm_phase;

  assign calm_phase = (sent_count >= 50) && (sent_count < 85);

  rice_code_bit_packer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_rice_k       (in_rice_k),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_word (out_packed_word),
    .out_last_of_run (out_last_of_run),
    .out_error_code  (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned low_bits(int unsigned n);
    return (n >= 32) ? 64'hFFFF_FFFF : ((64'd1 << n) - 64'd1);
  endfunction

  // Append one Rice code to the predicted bit stream, emitting full words.
  task automatic pack_code(longint unsigned val, int unsigned k);
    longint unsigned tail;
    longint unsigned run;
    longint unsigned total;
    int unsigned     ntail;
    int unsigned     fill;
    int unsigned     sh;
    tail  = (64'd1 << k) | (val & low_bits(k));
    run   = val >> k;
    ntail = k + 1;
    total = longint'(pend_fill) + run;
    repeat (total >> 5) begin
      expected_words.push_back('{word: pend_word, last: 1'b0, err: ERR_OK});
      pend_word = '0;
    end
    fill = int'(total & 31);
    while (ntail != 0) begin
      if (fill + ntail >= 32) begin
        sh = fill + ntail - 32;
        pend_word = pend_word | 32'(tail >> sh);
        expected_words.push_back('{word: pend_word, last: 1'b0, err: ERR_OK});
        pend_word = '0;
        ntail = ntail - (32 - fill);
        fill = 0;
      end else begin
        fill = fill + ntail;
        pend_word = pend_word | 32'(tail << (32 - fill));
        ntail = 0;
      end
    end
    pend_fill = fill[4:0];
  endtask

  task automatic predict_request(opcode_t op, logic [31:0] value, logic [5:0] rk);
    longint unsigned v;
    int unsigned     k;
    int unsigned     nbit;
    int              base;
    word_res_t       tail_res;
    base = expected_words.size();
    case (op)
      OP_UNSIGNED, OP_SIGNED: begin
        v = {32'd0, value};
        k = rk;
        if (op == OP_SIGNED) begin
          // fold the sign into bit 0
          k = rk + 1;
          v = value[31] ? (({32'd0, ~value} << 1) | 64'd1) : ({32'd0, value} << 1);
        end
        if (k > 32)
          expected_words.push_back('{word: '0, last: 1'b1, err: ERR_PARAM});
        else if ((v >> k) > MAX_ZERO_RUN_BITS)
          expected_words.push_back('{word: '0, last: 1'b1, err: ERR_RUN});
        else
          pack_code(v, k);
      end
      OP_LONG: begin
        nbit = 0;
        for (int i = 0; i < 32; i++)
          if (value[i]) nbit = i + 1;
        pack_code(nbit, 2);
        pack_code({32'd0, value} & low_bits(nbit), nbit);
      end
      default: begin
        // marker code, then drop what is left of the word
        pack_code(0, 31);
        pend_word = '0;
        pend_fill = '0;
      end
    endcase
    if (expected_words.size() > base) begin
      tail_res = expected_words.pop_back();
      tail_res.last = 1'b1;
      expected_words.push_back(tail_res);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_req(opcode_t op, logic [31:0] value, logic [5:0] rice_k);
    pending_reqs.push_back('{op: op, value: value, rice_k: rice_k});
  endtask

  // request driver
  always @(negedge clk) begin
    req_t next_req;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_reqs.size() != 0 && (calm_phase || $urandom_range(0, 99) >= 19)) begin
        next_req = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        in_opcode  <= next_req.op;
        in_value   <= next_req.value;
        in_rice_k  <= next_req.rice_k;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= 30) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm_phase && ($urandom_range(0, 99) < 19);
    end
  end

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin
    word_res_t want;
    logic      took_req;
    logic      took_res;
    took_req = rst_n && in_valid && !in_stall;
    took_res = rst_n && out_valid && !out_stall;
    if (took_res) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing expected", out_packed_word, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_packed_word !== want.word)
          report_mismatch("packed_word", out_packed_word, want.word);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(out_last_of_run), 32'(want.last));
        if (out_error_code !== want.err)
          report_mismatch("error_code", 32'(out_error_code), 32'(want.err));
      end
    end
    if (took_req)
      predict_request(opcode_t'(in_opcode), in_value, in_rice_k);
    in_fire <= took_req;
    idle_cycles <= (took_req || took_res || !rst_n) ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned     k;
    int unsigned     run;
    int unsigned     sel;
    int unsigned     sh;
    int signed       sv;
    longint unsigned wide;

    // directed requests
    add_req(OP_UNSIGNED, 32'd0, 6'd0);
    add_req(OP_UNSIGNED, 32'hFFFF_FFFF, 6'd32);
    add_req(OP_UNSIGNED, 32'd1984, 6'd0);
    add_req(OP_UNSIGNED, 32'd1985, 6'd0);
    add_req(OP_UNSIGNED, 32'hFFFF_FFFF, 6'd21);
    add_req(OP_UNSIGNED, 32'd5, 6'd33);
    add_req(OP_UNSIGNED, 32'd5, 6'd63);
    add_req(OP_UNSIGNED, 32'd3, 6'd1);
    add_req(OP_SIGNED, 32'h8000_0000, 6'd31);
    add_req(OP_SIGNED, 32'h7FFF_FFFF, 6'd31);
    add_req(OP_SIGNED, 32'hFFFF_FFFF, 6'd0);
    add_req(OP_SIGNED, 32'd0, 6'd0);
    add_req(OP_SIGNED, 32'd1, 6'd32);
    add_req(OP_SIGNED, 32'd2000, 6'd0);
    add_req(OP_SIGNED, 32'hFFFF_FC1F, 6'd0);
    add_req(OP_LONG, 32'd0, 6'd0);
    add_req(OP_LONG, 32'd1, 6'd63);
    add_req(OP_LONG, 32'hFFFF_FFFF, 6'd0);
    add_req(OP_LONG, 32'h8000_0000, 6'd17);
    add_req(OP_FLUSH, $urandom, 6'($urandom_range(0, 63)));
    add_req(OP_UNSIGNED, 32'h0000_1234, 6'd31);
    add_req(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
    add_req(OP_FLUSH, 32'd0, 6'd0);

    // random requests, mostly codes of sane length
    for (int i = 0; i < 80; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        k = $urandom_range(0, 32);
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1984) : $urandom_range(0, 40);
        wide = (longint'(run) << k) | ({32'd0, $urandom} & low_bits(k));
        add_req(OP_UNSIGNED, wide[31:0], 6'(k));
      end else if (sel < 50) begin
        k = $urandom_range(0, 31);
        sh = $urandom_range((k >= 26) ? 0 : 26 - k, 31);
        sv = $urandom;
        sv = sv >>> sh;
        add_req(OP_SIGNED, sv, 6'(k));
      end else if (sel < 70) begin
        wide = {32'd0, $urandom} >> $urandom_range(0, 32);
        add_req(OP_LONG, wide[31:0], 6'($urandom_range(0, 63)));
      end else if (sel < 78) begin
        add_req(OP_FLUSH, $urandom, 6'($urandom_range(0, 63)));
      end else begin
        add_req(opcode_t'($urandom_range(0, 3)), $urandom, 6'($urandom_range(0, 63)));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
